// File: hdl/bmhq_pkg.sv
// Shared constants and operation codes for the binary min-heap queue.
package bmhq_pkg;

  localparam int CAPACITY_DEF     = 256;
  localparam int KEY_BITS_DEF     = 32;
  localparam int PAYLOAD_BITS_DEF = 16;

  localparam int KEY_W   = 32;
  localparam int PAY_W   = 16;
  localparam int COUNT_W = 9;

  localparam logic [1:0] OP_INSERT  = 2'd0;
  localparam logic [1:0] OP_EXTRACT = 2'd1;
  localparam logic [1:0] OP_PEEK    = 2'd2;

endpackage

// File: hdl/binary_min_heap_queue.sv
// Binary min-heap priority queue with a sequenced sift unit over one heap memory.
//
// Usage: each input transaction carries kind (insert, extract minimum, peek
// minimum), key and payload, and produces exactly one result transaction with
// ok, out_key, out_payload and the entry count after the operation. Both
// channels use valid/ready. The block takes one transaction at a time:
// in_ready is high only while the sequencer is idle.
// Sequencing: a peek reads the root; a rejected or ignored operation goes
// straight to the result stage. An insert walks the tree upward one level at a
// time; an extract reads the root and last entry, then walks downward one level
// at a time. Each level of the sift loop issues a registered memory read and
// then one or two key compares followed by one memory write.
// Reset clears the entry count and the sequencer; heap contents are not
// cleared and need no clearing pass, since only entries below the count are
// read. A result waits in the output register while out_ready is low; the
// next transaction may be accepted meanwhile, but its result is held in the
// sequencer until the output register is free.
module binary_min_heap_queue #(
  parameter int CAPACITY     = bmhq_pkg::CAPACITY_DEF,
  parameter int KEY_BITS     = bmhq_pkg::KEY_BITS_DEF,
  parameter int PAYLOAD_BITS = bmhq_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   kind,
  input  logic [bmhq_pkg::KEY_W-1:0]   key,
  input  logic [bmhq_pkg::PAY_W-1:0]   payload,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         ok,
  output logic [bmhq_pkg::KEY_W-1:0]   out_key,
  output logic [bmhq_pkg::PAY_W-1:0]   out_payload,
  output logic [bmhq_pkg::COUNT_W-1:0] count
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CHL_W = IDX_W + 2;

  typedef struct packed {
    logic [KEY_BITS-1:0]     k;
    logic [PAYLOAD_BITS-1:0] p;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE, S_UP_RD, S_UP_CMP, S_RT_RD, S_RT_CMP, S_DN_RD, S_DN_CMP, S_DONE
  } state_t;

  state_t                  state;
  logic [1:0]              op;
  entry_t                  cur;
  logic [IDX_W-1:0]        idx;
  logic [CNT_W-1:0]        cnt;
  logic                    res_ok;
  logic [KEY_BITS-1:0]     res_key;
  logic [PAYLOAD_BITS-1:0] res_pay;

  entry_t                  mem [CAPACITY];
  entry_t                  rd_a;
  entry_t                  rd_b;
  logic [IDX_W-1:0]        ra;
  logic [IDX_W-1:0]        rb;
  logic                    we;
  logic [IDX_W-1:0]        wa;
  entry_t                  wd;

  logic [IDX_W-1:0]        par;
  logic [CHL_W-1:0]        lc;
  logic [CHL_W-1:0]        rc;
  logic [CHL_W-1:0]        cnt_x;
  logic                    l_out;
  logic                    pick_r;
  entry_t                  m_ent;
  logic [IDX_W-1:0]        m_idx;
  logic                    dn_stop;
  logic                    up_move;

  assign par     = (idx - 1'b1) >> 1;
  assign lc      = {1'b0, idx, 1'b1};
  assign rc      = lc + 1'b1;
  assign cnt_x   = CHL_W'(cnt);
  assign l_out   = (lc >= cnt_x);
  assign pick_r  = (rc < cnt_x) && (rd_a.k > rd_b.k);
  assign m_ent   = pick_r ? rd_b : rd_a;
  assign m_idx   = pick_r ? rc[IDX_W-1:0] : lc[IDX_W-1:0];
  assign dn_stop = (cur.k <= m_ent.k);
  assign up_move = (rd_a.k > cur.k);

  assign in_ready = (state == S_IDLE);

  // Read addresses and the single write port are steered by the sequencer state.
  always_comb begin
    ra = '0;
    rb = IDX_W'(cnt - 1'b1);
    we = 1'b0;
    wa = idx;
    wd = cur;
    unique case (state)
      S_UP_RD: begin
        ra = par;
        we = (idx == '0);
      end
      S_UP_CMP: begin
        we = 1'b1;
        if (up_move) begin
          wd = rd_a;
        end
      end
      S_DN_RD: begin
        ra = lc[IDX_W-1:0];
        rb = rc[IDX_W-1:0];
        we = l_out;
      end
      S_DN_CMP: begin
        we = 1'b1;
        if (!dn_stop) begin
          wd = m_ent;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_a <= mem[ra];
    rd_b <= mem[rb];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      // A new result loads in S_DONE; otherwise a taken result frees the register.
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op      <= kind;
            cur.k   <= KEY_BITS'(key);
            cur.p   <= PAYLOAD_BITS'(payload);
            res_ok  <= 1'b0;
            res_key <= '0;
            res_pay <= '0;
            state   <= S_DONE;
            case (kind) inside
              bmhq_pkg::OP_INSERT: begin
                if (cnt != CNT_W'(CAPACITY)) begin
                  idx   <= IDX_W'(cnt);
                  cnt   <= cnt + 1'b1;
                  state <= S_UP_RD;
                end
              end
              bmhq_pkg::OP_EXTRACT, bmhq_pkg::OP_PEEK: begin
                if (cnt != '0) begin
                  state <= S_RT_RD;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_UP_RD: begin
          if (idx == '0) begin
            res_ok <= 1'b1;
            state  <= S_DONE;
          end else begin
            state <= S_UP_CMP;
          end
        end
        S_UP_CMP: begin
          if (up_move) begin
            idx   <= par;
            state <= S_UP_RD;
          end else begin
            res_ok <= 1'b1;
            state  <= S_DONE;
          end
        end
        S_RT_RD: begin
          state <= S_RT_CMP;
        end
        S_RT_CMP: begin
          res_ok  <= 1'b1;
          res_key <= rd_a.k;
          res_pay <= rd_a.p;
          state   <= S_DONE;
          if (op == bmhq_pkg::OP_EXTRACT) begin
            cnt <= cnt - 1'b1;
            cur <= rd_b;
            idx <= '0;
            if (cnt != CNT_W'(1)) begin
              state <= S_DN_RD;
            end
          end
        end
        S_DN_RD: begin
          state <= l_out ? S_DONE : S_DN_CMP;
        end
        S_DN_CMP: begin
          if (dn_stop) begin
            state <= S_DONE;
          end else begin
            idx   <= m_idx;
            state <= S_DN_RD;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            ok          <= res_ok;
            out_key     <= bmhq_pkg::KEY_W'(res_key);
            out_payload <= bmhq_pkg::PAY_W'(res_pay);
            count       <= bmhq_pkg::COUNT_W'(cnt);
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The entry count never passes the capacity.
  a_cnt_cap: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // Every heap write lands inside the live region of the array.
  a_wr_live: assert property (@(posedge clk) disable iff (rst)
    we |-> (CHL_W'(wa) < cnt_x))
    else $error("heap write beyond entry count");

  // The sift hole always stays below the entry count.
  a_idx_live: assert property (@(posedge clk) disable iff (rst)
    (state == S_UP_RD || state == S_UP_CMP || state == S_DN_RD || state == S_DN_CMP)
    |-> (CHL_W'(idx) < cnt_x))
    else $error("sift index beyond entry count");

  // A failed operation reports no entry.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !ok) |-> (out_key == '0 && out_payload == '0))
    else $error("failed operation reported an entry");

  // Only one transaction is in the sequencer at a time.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("sequencer accepted a second transaction");

endmodule

// File: sim/tb.sv
// Self-checking testbench for the binary min-heap queue with a scoreboard that mirrors the heap.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int HEAP_SLOTS = bmhq_pkg::CAPACITY_DEF;
  localparam int TAIL_CYCLES = 40;
  localparam int MAX_GAP = 40;

  // Mirror of the heap contents plus the answers still owed by the block.
  class heap_shadow;
    logic [bmhq_pkg::KEY_W-1:0] keys [0:bmhq_pkg::CAPACITY_DEF-1];
    logic [bmhq_pkg::PAY_W-1:0] pays [0:bmhq_pkg::CAPACITY_DEF-1];
    int unsigned entries;
    int mismatches;
    logic want_ok [$];
    logic [bmhq_pkg::KEY_W-1:0] want_key [$];
    logic [bmhq_pkg::PAY_W-1:0] want_pay [$];
    logic [bmhq_pkg::COUNT_W-1:0] want_count [$];

    function new();
      entries = 0;
      mismatches = 0;
    endfunction

    function void swap_slots(int unsigned a, int unsigned b);
      logic [bmhq_pkg::KEY_W-1:0] tk;
      logic [bmhq_pkg::PAY_W-1:0] tp;
      tk = keys[a];
      tp = pays[a];
      keys[a] = keys[b];
      pays[a] = pays[b];
      keys[b] = tk;
      pays[b] = tp;
    endfunction

    // Applies one accepted operation and queues the answer it must produce.
    function void apply_op(logic [1:0] op, logic [bmhq_pkg::KEY_W-1:0] k,
                           logic [bmhq_pkg::PAY_W-1:0] p);
      logic res_ok;
      logic [bmhq_pkg::KEY_W-1:0] res_key;
      logic [bmhq_pkg::PAY_W-1:0] res_pay;
      logic [bmhq_pkg::COUNT_W-1:0] res_count;
      int unsigned idx, par, lft, rgt, pick;
      res_ok = 1'b0;
      res_key = '0;
      res_pay = '0;
      case (op) inside
        bmhq_pkg::OP_INSERT: begin
          if (entries < bmhq_pkg::CAPACITY_DEF) begin
            idx = entries;
            keys[idx] = k;
            pays[idx] = p;
            entries++;
            while (idx != 0) begin
              par = (idx - 1) / 2;
              if (keys[par] <= keys[idx]) break;
              swap_slots(idx, par);
              idx = par;
            end
            res_ok = 1'b1;
          end
        end
        bmhq_pkg::OP_EXTRACT, bmhq_pkg::OP_PEEK: begin
          if (entries > 0) begin
            res_ok = 1'b1;
            res_key = keys[0];
            res_pay = pays[0];
            if (op == bmhq_pkg::OP_EXTRACT) begin
              entries--;
              if (entries > 0) begin
                keys[0] = keys[entries];
                pays[0] = pays[entries];
                idx = 0;
                // Walk down toward the smaller child; the left one wins a tie.
                while (1) begin
                  lft = 2 * idx + 1;
                  rgt = lft + 1;
                  if (lft >= entries) break;
                  pick = lft;
                  if (rgt < entries && keys[lft] > keys[rgt]) pick = rgt;
                  if (keys[idx] <= keys[pick]) break;
                  swap_slots(idx, pick);
                  idx = pick;
                end
              end
            end
          end
        end
        default: ;
      endcase
      res_count = bmhq_pkg::COUNT_W'(entries);
      want_ok.push_back(res_ok);
      want_key.push_back(res_key);
      want_pay.push_back(res_pay);
      want_count.push_back(res_count);
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH at %0t ns: %s", $time, msg);
      mismatches++;
    endtask

    task check_answer(logic o, logic [bmhq_pkg::KEY_W-1:0] k, logic [bmhq_pkg::PAY_W-1:0] p,
                      logic [bmhq_pkg::COUNT_W-1:0] c);
      logic e_ok;
      logic [bmhq_pkg::KEY_W-1:0] e_key;
      logic [bmhq_pkg::PAY_W-1:0] e_pay;
      logic [bmhq_pkg::COUNT_W-1:0] e_count;
      if (want_ok.size() == 0) begin
        report_mismatch($sformatf("result transaction with none pending (ok=%0b key=%h)", o, k));
        return;
      end
      e_ok = want_ok.pop_front();
      e_key = want_key.pop_front();
      e_pay = want_pay.pop_front();
      e_count = want_count.pop_front();
      if (o !== e_ok)
        report_mismatch($sformatf("ok got %b want %b", o, e_ok));
      if (k !== e_key)
        report_mismatch($sformatf("out_key got %h want %h", k, e_key));
      if (p !== e_pay)
        report_mismatch($sformatf("out_payload got %h want %h", p, e_pay));
      if (c !== e_count)
        report_mismatch($sformatf("count got %0d want %0d", c, e_count));
    endtask

    function int pending();
      return want_ok.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [1:0] kind;
  logic [bmhq_pkg::KEY_W-1:0] key;
  logic [bmhq_pkg::PAY_W-1:0] payload;
  logic out_valid;
  logic out_ready;
  logic ok;
  logic [bmhq_pkg::KEY_W-1:0] out_key;
  logic [bmhq_pkg::PAY_W-1:0] out_payload;
  logic [bmhq_pkg::COUNT_W-1:0] count;

  int send_idle_pct;
  int stall_pct;
  heap_shadow shadow;

  binary_min_heap_queue uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .kind(kind),
    .key(key),
    .payload(payload),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .ok(ok),
    .out_key(out_key),
    .out_payload(out_payload),
    .count(count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      shadow.check_answer(ok, out_key, out_payload, count);
  end

  // Keys lean toward a narrow range so that equal keys and ties show up often.
  function automatic logic [bmhq_pkg::KEY_W-1:0] rand_key();
    int r;
    r = $urandom_range(99);
    if (r < 50) return bmhq_pkg::KEY_W'($urandom);
    if (r < 80) return bmhq_pkg::KEY_W'($urandom_range(15));
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      2: return 32'h8000_0000;
      default: return 32'h7FFF_FFFF;
    endcase
  endfunction

  function automatic logic [bmhq_pkg::PAY_W-1:0] rand_payload();
    int r;
    r = $urandom_range(19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return bmhq_pkg::PAY_W'($urandom_range(65535));
  endfunction

  function automatic logic [bmhq_pkg::PAY_W-1:0] rand_pay_any();
    return bmhq_pkg::PAY_W'($urandom);
  endfunction

  // Presents one transaction, with a random idle gap first, and holds it until accepted.
  task automatic send_op(logic [1:0] op, logic [bmhq_pkg::KEY_W-1:0] k,
                         logic [bmhq_pkg::PAY_W-1:0] p);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    kind <= op;
    key <= k;
    payload <= p;
    do @(posedge clk); while (!in_ready);
    shadow.apply_op(op, k, p);
  endtask

  initial begin
    int mode;
    int r;
    shadow = new();
    send_idle_pct = 0;
    stall_pct = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    kind = bmhq_pkg::OP_INSERT;
    key = '0;
    payload = '0;
    out_ready = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Empty-heap answers, the unused code, extremes and equal keys.
    send_op(bmhq_pkg::OP_PEEK, '0, '0);
    send_op(bmhq_pkg::OP_EXTRACT, '1, '1);
    send_op(OP_UNUSED, '0, '0);
    send_op(bmhq_pkg::OP_INSERT, '1, '1);
    send_op(bmhq_pkg::OP_INSERT, '0, '0);
    send_op(bmhq_pkg::OP_INSERT, 32'h8000_0000, 16'h8000);
    send_op(bmhq_pkg::OP_INSERT, '0, 16'h1234);
    send_op(bmhq_pkg::OP_INSERT, '1, 16'h0001);
    send_op(bmhq_pkg::OP_PEEK, 32'h5A5A_5A5A, 16'hA5A5);
    send_op(OP_UNUSED, '1, '1);
    repeat (6) send_op(bmhq_pkg::OP_EXTRACT, '0, '0);
    send_op(bmhq_pkg::OP_INSERT, 32'd5, 16'hAAAA);
    send_op(bmhq_pkg::OP_INSERT, 32'd5, 16'h5555);
    send_op(bmhq_pkg::OP_INSERT, 32'd5, 16'h0F0F);
    send_op(bmhq_pkg::OP_EXTRACT, '0, '0);
    send_op(bmhq_pkg::OP_EXTRACT, '0, '0);
    send_op(bmhq_pkg::OP_PEEK, '0, '0);
    send_op(bmhq_pkg::OP_EXTRACT, '0, '0);
    send_op(bmhq_pkg::OP_EXTRACT, '0, '0);
    send_op(bmhq_pkg::OP_PEEK, '1, '1);

    for (mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin send_idle_pct = 0; stall_pct = 0; end
        1: begin send_idle_pct = 51; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 51; end
        default: begin send_idle_pct = 35; stall_pct = 35; end
      endcase
      repeat (300) begin
        r = $urandom_range(99);
        if (r < 47)
          send_op(bmhq_pkg::OP_INSERT, rand_key(), rand_payload());
        else if (r < 82)
          send_op(bmhq_pkg::OP_EXTRACT, $urandom, rand_pay_any());
        else if (r < 96)
          send_op(bmhq_pkg::OP_PEEK, $urandom, rand_pay_any());
        else
          send_op(OP_UNUSED, $urandom, rand_pay_any());
      end
    end

    // Fill to capacity, push against the full heap, then drain past empty.
    while (shadow.entries < HEAP_SLOTS) begin
      r = $urandom_range(99);
      if (r < 90)
        send_op(bmhq_pkg::OP_INSERT, rand_key(), rand_payload());
      else if (r < 97)
        send_op(bmhq_pkg::OP_PEEK, $urandom, rand_pay_any());
      else
        send_op(OP_UNUSED, $urandom, rand_pay_any());
    end
    repeat (6) send_op(bmhq_pkg::OP_INSERT, rand_key(), rand_payload());
    send_op(bmhq_pkg::OP_PEEK, '0, '0);
    while (shadow.entries > 0) begin
      if ($urandom_range(99) < 92)
        send_op(bmhq_pkg::OP_EXTRACT, $urandom, rand_pay_any());
      else
        send_op(bmhq_pkg::OP_PEEK, $urandom, rand_pay_any());
    end
    repeat (3) send_op(bmhq_pkg::OP_EXTRACT, '0, '0);

    @(negedge clk);
    in_valid <= 1'b0;
    while (shadow.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (shadow.mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
